/* design/rbd_pkg.sv */
// Shared types, constants and helpers for the retro bus decoder.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rbd_pkg;

   // Storage sizes
   localparam int KEY_QUEUE_DEPTH = 16;
   localparam int RAM_BYTES       = 49152;
   localparam int ROM_BYTES       = 12288;

   localparam int KQ_AW  = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
   localparam int KQ_CW  = $clog2(KEY_QUEUE_DEPTH + 1);
   localparam int RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
   localparam int ROM_AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

   // Memory map
   localparam logic [15:0] IO_BASE   = 16'hC000;
   localparam logic [15:0] SLOT_BASE = 16'hC100;
   localparam logic [15:0] ROM_BASE  = 16'hD000;

   // I/O page groups, address bits [7:4]
   localparam logic [3:0] IO_GRP_KBD     = 4'h0;
   localparam logic [3:0] IO_GRP_STROBE  = 4'h1;
   localparam logic [3:0] IO_GRP_SPEAKER = 4'h3;
   localparam logic [3:0] IO_GRP_SWITCH  = 4'h5;

   // Soft switch locations within the switch group, address bits [3:0]
   localparam logic [3:0] SW_TEXT_OFF  = 4'h0;
   localparam logic [3:0] SW_TEXT_ON   = 4'h1;
   localparam logic [3:0] SW_MIXED_OFF = 4'h2;
   localparam logic [3:0] SW_MIXED_ON  = 4'h3;
   localparam logic [3:0] SW_PAGE1     = 4'h4;
   localparam logic [3:0] SW_PAGE2     = 4'h5;
   localparam logic [3:0] SW_LORES     = 4'h6;
   localparam logic [3:0] SW_HIRES     = 4'h7;

   // Keyboard
   localparam logic [7:0] KEY_STROBE = 8'h80;
   localparam logic [7:0] KEY_CHAR   = 8'h7F;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_LF     = 8'h0A;
   localparam logic [7:0] KEY_CASE   = 8'h20;

   typedef enum logic [2:0] {
      CMD_READ     = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_TYPE_KEY = 3'd2,
      CMD_FEED     = 3'd3,
      CMD_ROM_LOAD = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch request, launch memory reads
      logic execute;   // apply the command, load the result
   } ctrl_cmd_type;

   // Upper-case letters, fold LF into CR, keep 7 bits
   function automatic logic [6:0] key_normalize(input logic [7:0] c);
      logic [7:0] v;
      v = c;
      if (c inside {[8'h61:8'h7A]}) begin
         v = c - KEY_CASE;
      end
      if (c inside {KEY_LF, KEY_CR}) begin
         v = KEY_CR;
      end
      return v[6:0];
   endfunction

endpackage

/* design/rbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rbd_ctrl.sv */
// Controller for the retro bus decoder: accept / execute sequencing.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output rbd_pkg::ctrl_cmd_type ctrl_cmd
);
   import rbd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      busy             = 1'b1;
      ctrl_cmd.capture = 1'b0;
      ctrl_cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy             = reset;
            ctrl_cmd.capture = start && !reset;
         end
         ST_EXEC: ctrl_cmd.execute = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

/* design/rbd_datapath.sv */
// Datapath for the retro bus decoder: RAM, ROM, key queue, I/O page state.
// Depends on rbd_pkg and rbd_ram.
`timescale 1ns / 1ps

module rbd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rbd_pkg::ctrl_cmd_type ctrl_cmd,
   input  logic [2:0]            req_command,
   input  logic [15:0]           req_address,
   input  logic [7:0]            req_data,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_key_dropped,
   output logic                  rsp_text_mode,
   output logic                  rsp_mixed_mode,
   output logic                  rsp_second_page,
   output logic                  rsp_hires_mode,
   output logic [3:0]            rsp_annunciator_bits,
   output logic [31:0]           rsp_speaker_count,
   output logic [4:0]            rsp_keys_waiting
);
   import rbd_pkg::*;

   // Captured request
   cmd_type     cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   // Machine state
   logic [7:0]       latch_ff,  latch_in;
   logic [KQ_AW-1:0] head_ff,   head_in;
   logic [KQ_AW-1:0] tail_ff,   tail_in;
   logic [KQ_CW-1:0] count_ff,  count_in;
   logic             text_ff,   text_in;
   logic             mixed_ff,  mixed_in;
   logic             page2_ff,  page2_in;
   logic             hires_ff,  hires_in;
   logic [3:0]       ann_ff,    ann_in;
   logic [31:0]      toggle_ff, toggle_in;
   logic             loaded_ff, loaded_in;

   // Result
   logic       strobe_ff;
   logic [7:0] rd_ff,   rd_in;
   logic       drop_ff, drop_in;

   // Memory ports
   logic       ram_we;
   logic [7:0] ram_q;
   logic       rom_we;
   logic [7:0] rom_q;
   logic       kq_we;
   logic [6:0] kq_q;

   // Decode of the captured address
   logic [15:0] rom_off;
   logic [15:0] req_rom_off;
   logic        is_ram, is_io, is_rom;
   logic        ram_hit, rom_hit, bus_cmd;
   logic [7:0]  io_rd;

   assign rom_off     = addr_ff - ROM_BASE;
   assign req_rom_off = req_address - ROM_BASE;
   assign is_ram      = addr_ff < IO_BASE;
   assign is_io       = (addr_ff >= IO_BASE) && (addr_ff < SLOT_BASE);
   assign is_rom      = addr_ff >= ROM_BASE;
   assign ram_hit     = is_ram && (addr_ff < 16'(RAM_BYTES));
   assign rom_hit     = is_rom && loaded_ff && (rom_off < 16'(ROM_BYTES));
   assign bus_cmd     = (cmd_ff == CMD_READ) || (cmd_ff == CMD_WRITE);

   // Memories: reads launch at the accept edge, writes land at the execute edge
   rbd_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_main_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff[RAM_AW-1:0]),
      .wr_data (data_ff),
      .rd_en   (ctrl_cmd.capture),
      .rd_addr (req_address[RAM_AW-1:0]),
      .rd_data (ram_q)
   );

   rbd_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
      .clock   (clock),
      .wr_en   (rom_we),
      .wr_addr (addr_ff[ROM_AW-1:0]),
      .wr_data (data_ff),
      .rd_en   (ctrl_cmd.capture),
      .rd_addr (req_rom_off[ROM_AW-1:0]),
      .rd_data (rom_q)
   );

   rbd_ram #(.WIDTH(7), .DEPTH(KEY_QUEUE_DEPTH)) u_key_queue (
      .clock   (clock),
      .wr_en   (kq_we),
      .wr_addr (tail_ff),
      .wr_data (key_normalize(data_ff)),
      .rd_en   (ctrl_cmd.capture),
      .rd_addr (head_ff),
      .rd_data (kq_q)
   );

   // Request capture
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff  <= cmd_type'(req_command);
         addr_ff <= req_address;
         data_ff <= req_data;
      end
   end

   // I/O page access: value and side effects
   always_comb begin
      io_rd     = 8'h00;
      latch_in  = latch_ff;
      toggle_in = toggle_ff;
      text_in   = text_ff;
      mixed_in  = mixed_ff;
      page2_in  = page2_ff;
      hires_in  = hires_ff;
      ann_in    = ann_ff;
      if (ctrl_cmd.execute && bus_cmd && is_io) begin
         case (addr_ff[7:4])
            IO_GRP_KBD: io_rd = latch_ff;
            IO_GRP_STROBE: begin
               latch_in = latch_ff & KEY_CHAR;
               io_rd    = latch_ff & KEY_CHAR;
            end
            IO_GRP_SPEAKER: toggle_in = toggle_ff + 32'd1;
            IO_GRP_SWITCH: begin
               case (addr_ff[3:0])
                  SW_TEXT_OFF:  text_in  = 1'b0;
                  SW_TEXT_ON:   text_in  = 1'b1;
                  SW_MIXED_OFF: mixed_in = 1'b0;
                  SW_MIXED_ON:  mixed_in = 1'b1;
                  SW_PAGE1:     page2_in = 1'b0;
                  SW_PAGE2:     page2_in = 1'b1;
                  SW_LORES:     hires_in = 1'b0;
                  SW_HIRES:     hires_in = 1'b1;
                  // upper eight: annunciator pairs, odd sets, even clears
                  default:      ann_in[addr_ff[2:1]] = addr_ff[0];
               endcase
            end
            default: io_rd = 8'h00;
         endcase
      end
      // key feed moves the oldest key into an acknowledged latch
      if (ctrl_cmd.execute && (cmd_ff == CMD_FEED) && (count_ff != '0)
          && !latch_ff[7]) begin
         latch_in = KEY_STROBE | {1'b0, kq_q};
      end
   end

   // Command execution: memories, key queue, result
   always_comb begin
      rd_in     = 8'h00;
      drop_in   = 1'b0;
      ram_we    = 1'b0;
      rom_we    = 1'b0;
      kq_we     = 1'b0;
      loaded_in = loaded_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      if (ctrl_cmd.execute) begin
         case (cmd_ff)
            CMD_READ: begin
               if (is_ram) begin
                  rd_in = ram_hit ? ram_q : 8'h00;
               end else if (is_io) begin
                  rd_in = io_rd;
               end else begin
                  rd_in = rom_hit ? rom_q : 8'h00;
               end
            end
            CMD_WRITE: begin
               ram_we = ram_hit;
               rd_in  = is_io ? io_rd : 8'h00;
            end
            CMD_TYPE_KEY: begin
               if (count_ff == KQ_CW'(KEY_QUEUE_DEPTH)) begin
                  drop_in = 1'b1;
               end else begin
                  kq_we    = 1'b1;
                  count_in = count_ff + 1'b1;
                  tail_in  = (tail_ff == KQ_AW'(KEY_QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               end
            end
            CMD_FEED: begin
               if ((count_ff != '0) && !latch_ff[7]) begin
                  count_in = count_ff - 1'b1;
                  head_in  = (head_ff == KQ_AW'(KEY_QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               end
            end
            CMD_ROM_LOAD: begin
               if (addr_ff < 16'(ROM_BYTES)) begin
                  rom_we    = 1'b1;
                  loaded_in = 1'b1;
               end
            end
            default: rd_in = 8'h00;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff  <= 8'h00;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         text_ff   <= 1'b1;
         mixed_ff  <= 1'b0;
         page2_ff  <= 1'b0;
         hires_ff  <= 1'b0;
         ann_ff    <= 4'h0;
         toggle_ff <= 32'd0;
         loaded_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         latch_ff  <= latch_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         text_ff   <= text_in;
         mixed_ff  <= mixed_in;
         page2_ff  <= page2_in;
         hires_ff  <= hires_in;
         ann_ff    <= ann_in;
         toggle_ff <= toggle_in;
         loaded_ff <= loaded_in;
         strobe_ff <= ctrl_cmd.execute;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (ctrl_cmd.execute) begin
         rd_ff   <= rd_in;
         drop_ff <= drop_in;
      end
   end

   // State registers already hold post-command values during the strobe
   assign rsp_strobe           = strobe_ff;
   assign rsp_read_data        = rd_ff;
   assign rsp_key_dropped      = drop_ff;
   assign rsp_text_mode        = text_ff;
   assign rsp_mixed_mode       = mixed_ff;
   assign rsp_second_page      = page2_ff;
   assign rsp_hires_mode       = hires_ff;
   assign rsp_annunciator_bits = ann_ff;
   assign rsp_speaker_count    = toggle_ff;
   assign rsp_keys_waiting     = 5'(count_ff);

endmodule

/* design/retro_bus_decode_soft_switches.sv */
// Retro bus decoder top level: memory map, I/O page soft switches, key queue.
// The result strobe is registered from the execute state that follows an accept.
// A new command is not taken before the last has executed: busy is high in the execute
// state after an accept, which waits out the registered read of the RAM, ROM and key queue memories.
// Reset (synchronous): clears control, latch, switches, counters and queue pointers;
// RAM, ROM and queue contents are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module retro_bus_decode_soft_switches (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_key_dropped,
   output logic        rsp_text_mode,
   output logic        rsp_mixed_mode,
   output logic        rsp_second_page,
   output logic        rsp_hires_mode,
   output logic [3:0]  rsp_annunciator_bits,
   output logic [31:0] rsp_speaker_count,
   output logic [4:0]  rsp_keys_waiting
);
   import rbd_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   rbd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .ctrl_cmd (ctrl_cmd)
   );

   rbd_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl_cmd             (ctrl_cmd),
      .req_command          (req_command),
      .req_address          (req_address),
      .req_data             (req_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_read_data        (rsp_read_data),
      .rsp_key_dropped      (rsp_key_dropped),
      .rsp_text_mode        (rsp_text_mode),
      .rsp_mixed_mode       (rsp_mixed_mode),
      .rsp_second_page      (rsp_second_page),
      .rsp_hires_mode       (rsp_hires_mode),
      .rsp_annunciator_bits (rsp_annunciator_bits),
      .rsp_speaker_count    (rsp_speaker_count),
      .rsp_keys_waiting     (rsp_keys_waiting)
   );

`ifndef ASSERT_OFF
   // Every transfer in gives a result strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("missing result strobe after transfer");

   // No strobe without an earlier transfer
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without a transfer");

   // Busy holds for the execute cycle
   a_busy_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low during execute");

   // A dropped key means the queue is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_key_dropped) |-> (rsp_keys_waiting == 5'(KEY_QUEUE_DEPTH)))
      else $error("key dropped with room in the queue");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for retro_bus_decode_soft_switches: bus, keyboard and
// ROM-load commands checked response by response against a behavioral predictor.
// Depends on rbd_pkg and the DUT only.
`timescale 1ns / 1ps

module tb_top;
   import rbd_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 12;
   localparam int PHASE_ITEMS  = 340;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int DUE_SLOTS    = 16;

   // Command codes the block does not define, and other test constants
   localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
   localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
   localparam logic [15:0] SLOT_LAST    = 16'hCFFF;
   localparam logic [15:0] ADDR_TOP     = 16'hFFFF;
   localparam logic [3:0]  IO_GRP_OTHER = 4'h2;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        key_dropped;
      logic        text_mode;
      logic        mixed_mode;
      logic        second_page;
      logic        hires_mode;
      logic [3:0]  annunciators;
      logic [31:0] speaker;
      logic [4:0]  keys_waiting;
   } bus_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_read_data;
   logic        rsp_key_dropped;
   logic        rsp_text_mode;
   logic        rsp_mixed_mode;
   logic        rsp_second_page;
   logic        rsp_hires_mode;
   logic [3:0]  rsp_annunciator_bits;
   logic [31:0] rsp_speaker_count;
   logic [4:0]  rsp_keys_waiting;

   // Machine image kept by the predictor
   logic [7:0]  kbd_latch = '0;
   logic [6:0]  kbd_queue [KEY_QUEUE_DEPTH];
   int unsigned kbd_head = 0;
   int unsigned kbd_count = 0;
   logic        vid_text = 1'b1;
   logic        vid_mixed = 1'b0;
   logic        vid_page2 = 1'b0;
   logic        vid_hires = 1'b0;
   logic [3:0]  ann_bits = '0;
   logic [31:0] spk_count = '0;
   logic [7:0]  ram_img [RAM_BYTES];
   bit          ram_valid [RAM_BYTES];
   logic [7:0]  rom_img [ROM_BYTES];
   bit          rom_valid [ROM_BYTES];
   bit          rom_ready = 1'b0;
   logic [15:0] ram_written [RAM_BYTES];
   int unsigned ram_written_n = 0;
   logic [15:0] rom_written [ROM_BYTES];
   int unsigned rom_written_n = 0;

   // Expected responses, oldest at due_rd
   bus_reply_type replies_due [DUE_SLOTS];
   int unsigned   due_wr = 0;
   int unsigned   due_rd = 0;
   bus_reply_type reply_head;
   int unsigned idle_pct = 0;
   int unsigned items_sent = 0;
   int unsigned replies_seen = 0;
   int unsigned keys_dropped = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   retro_bus_decode_soft_switches DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_address(req_address),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_read_data(rsp_read_data),
      .rsp_key_dropped(rsp_key_dropped),
      .rsp_text_mode(rsp_text_mode),
      .rsp_mixed_mode(rsp_mixed_mode),
      .rsp_second_page(rsp_second_page),
      .rsp_hires_mode(rsp_hires_mode),
      .rsp_annunciator_bits(rsp_annunciator_bits),
      .rsp_speaker_count(rsp_speaker_count),
      .rsp_keys_waiting(rsp_keys_waiting)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // I/O page access; reads and writes have the same side effects
   function automatic logic [7:0] io_touch(input logic [15:0] addr);
      logic [7:0] value;
      value = '0;
      case (addr[7:4])
         IO_GRP_KBD: begin
            value = kbd_latch;
         end
         IO_GRP_STROBE: begin
            kbd_latch = kbd_latch & KEY_CHAR;
            value = kbd_latch;
         end
         IO_GRP_SPEAKER: begin
            spk_count = spk_count + 32'd1;
         end
         IO_GRP_SWITCH: begin
            case (addr[3:0])
               SW_TEXT_OFF:  vid_text = 1'b0;
               SW_TEXT_ON:   vid_text = 1'b1;
               SW_MIXED_OFF: vid_mixed = 1'b0;
               SW_MIXED_ON:  vid_mixed = 1'b1;
               SW_PAGE1:     vid_page2 = 1'b0;
               SW_PAGE2:     vid_page2 = 1'b1;
               SW_LORES:     vid_hires = 1'b0;
               SW_HIRES:     vid_hires = 1'b1;
               // upper half: annunciator pairs, odd address sets
               default:      ann_bits[addr[2:1]] = addr[0];
            endcase
         end
         default: ;
      endcase
      return value;
   endfunction

   // Apply one command to the machine image, return the expected response
   function automatic bus_reply_type bus_step(input logic [2:0] cmd,
                                              input logic [15:0] addr,
                                              input logic [7:0] data);
      bus_reply_type r;
      logic [7:0] key;
      r = '0;
      case (cmd)
         CMD_READ: begin
            if (addr < IO_BASE) begin
               r.read_data = (addr < RAM_BYTES) ? ram_img[addr] : '0;
            end else if (addr < SLOT_BASE) begin
               r.read_data = io_touch(addr);
            end else if (addr >= ROM_BASE && rom_ready && (addr - ROM_BASE) < ROM_BYTES) begin
               r.read_data = rom_img[addr - ROM_BASE];
            end
         end
         CMD_WRITE: begin
            if (addr < IO_BASE) begin
               if (addr < RAM_BYTES) begin
                  if (!ram_valid[addr]) begin
                     ram_written[ram_written_n] = addr;
                     ram_written_n++;
                  end
                  ram_img[addr] = data;
                  ram_valid[addr] = 1'b1;
               end
            end else if (addr < SLOT_BASE) begin
               r.read_data = io_touch(addr);
            end
         end
         CMD_TYPE_KEY: begin
            key = data;
            if (data >= CHAR_LOWER_A && data <= CHAR_LOWER_Z) key = data - KEY_CASE;
            if (data == KEY_LF || data == KEY_CR) key = KEY_CR;
            if (kbd_count >= KEY_QUEUE_DEPTH) begin
               r.key_dropped = 1'b1;
               keys_dropped++;
            end else begin
               kbd_queue[(kbd_head + kbd_count) % KEY_QUEUE_DEPTH] = key[6:0];
               kbd_count++;
            end
         end
         CMD_FEED: begin
            // moves only into an acknowledged latch
            if (kbd_count != 0 && !kbd_latch[7]) begin
               kbd_latch = KEY_STROBE | {1'b0, kbd_queue[kbd_head]};
               kbd_head = (kbd_head + 1) % KEY_QUEUE_DEPTH;
               kbd_count--;
            end
         end
         CMD_ROM_LOAD: begin
            if (addr < ROM_BYTES) begin
               if (!rom_valid[addr]) begin
                  rom_written[rom_written_n] = addr;
                  rom_written_n++;
               end
               rom_img[addr] = data;
               rom_valid[addr] = 1'b1;
               rom_ready = 1'b1;
            end
         end
         default: ;
      endcase
      r.text_mode    = vid_text;
      r.mixed_mode   = vid_mixed;
      r.second_page  = vid_page2;
      r.hires_mode   = vid_hires;
      r.annunciators = ann_bits;
      r.speaker      = spk_count;
      r.keys_waiting = kbd_count[4:0];
      return r;
   endfunction

   // One command transfer, with an optional idle gap in front of it
   task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] addr,
                           input logic [7:0] data);
      int unsigned gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command <= cmd;
      req_address <= addr;
      req_data    <= data;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      replies_due[due_wr % DUE_SLOTS] = bus_step(cmd, addr, data);
      due_wr++;
      items_sent++;
   endtask

   // Stop sending and let every outstanding response come back
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (due_rd != due_wr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   // Response checker: every strobe pairs with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         replies_seen++;
         if (due_rd == due_wr) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] response with none expected, read_data 0x%0h",
                        $time, rsp_read_data);
         end else begin
            reply_head = replies_due[due_rd % DUE_SLOTS];
            due_rd++;
            check_field("read_data", 32'(reply_head.read_data), 32'(rsp_read_data));
            check_field("key_dropped", 32'(reply_head.key_dropped), 32'(rsp_key_dropped));
            check_field("text_mode", 32'(reply_head.text_mode), 32'(rsp_text_mode));
            check_field("mixed_mode", 32'(reply_head.mixed_mode), 32'(rsp_mixed_mode));
            check_field("second_page", 32'(reply_head.second_page), 32'(rsp_second_page));
            check_field("hires_mode", 32'(reply_head.hires_mode), 32'(rsp_hires_mode));
            check_field("annunciator_bits", 32'(reply_head.annunciators),
                        32'(rsp_annunciator_bits));
            check_field("speaker_count", reply_head.speaker, rsp_speaker_count);
            check_field("keys_waiting", 32'(reply_head.keys_waiting), 32'(rsp_keys_waiting));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("retro_bus_decode_soft_switches test failed");
         $finish;
      end
   end

   // ROM window: unloaded reads, out-of-range load, both ends, ignored write
   task automatic test_rom_window();
      send_cmd(CMD_READ, ROM_BASE, '0);
      send_cmd(CMD_ROM_LOAD, ADDR_TOP, 8'hFF);
      send_cmd(CMD_READ, ADDR_TOP, '0);
      send_cmd(CMD_ROM_LOAD, '0, 8'hA5);
      send_cmd(CMD_ROM_LOAD, 16'(ROM_BYTES - 1), 8'h5A);
      send_cmd(CMD_READ, ROM_BASE, '0);
      send_cmd(CMD_READ, ADDR_TOP, '0);
      send_cmd(CMD_WRITE, ROM_BASE, 8'hFF);
      send_cmd(CMD_READ, ROM_BASE, '0);
      wait_idle();
   endtask

   // RAM at both ends, slot area ignored
   task automatic test_ram_and_slots();
      send_cmd(CMD_WRITE, '0, 8'hFF);
      send_cmd(CMD_WRITE, IO_BASE - 16'd1, 8'h00);
      send_cmd(CMD_READ, '0, '0);
      send_cmd(CMD_READ, IO_BASE - 16'd1, '0);
      send_cmd(CMD_WRITE, SLOT_BASE, 8'h3C);
      send_cmd(CMD_READ, SLOT_LAST, '0);
      wait_idle();
   endtask

   // Soft switches, annunciator, speaker and unassigned I/O locations
   task automatic test_io_page();
      send_cmd(CMD_WRITE, {IO_BASE[15:8], IO_GRP_SWITCH, SW_TEXT_OFF}, 8'h55);
      send_cmd(CMD_READ, {IO_BASE[15:8], IO_GRP_SWITCH, SW_HIRES}, '0);
      send_cmd(CMD_WRITE, {IO_BASE[15:8], IO_GRP_SWITCH, 4'hF}, '0);
      send_cmd(CMD_READ, {IO_BASE[15:8], IO_GRP_SPEAKER, 4'h0}, '0);
      send_cmd(CMD_READ, {IO_BASE[15:8], IO_GRP_OTHER, 4'h7}, '0);
      send_cmd(CMD_WRITE, {IO_BASE[15:8], 8'hFF}, 8'hFF);
      wait_idle();
   endtask

   task automatic test_keyboard_basics();
      send_cmd(CMD_FEED, '0, '0);                // empty queue: no move
      send_cmd(CMD_TYPE_KEY, '0, CHAR_LOWER_A);  // upper-cased
      send_cmd(CMD_TYPE_KEY, '0, KEY_LF);        // folded to CR
      send_cmd(CMD_FEED, '0, '0);
      send_cmd(CMD_FEED, '0, '0);                // strobe still set: no move
      send_cmd(CMD_WRITE, IO_BASE, 8'hFF);       // latch write returns latch
      send_cmd(CMD_READ, {IO_BASE[15:8], IO_GRP_STROBE, 4'hF}, '0);
      send_cmd(CMD_FEED, ADDR_TOP, 8'hFF);
      wait_idle();
   endtask

   task automatic test_spare_commands();
      send_cmd(CMD_SPARE_LO, ADDR_TOP, 8'hFF);
      send_cmd(CMD_SPARE_HI, '0, '0);
      wait_idle();
   endtask

   // Random mix of traffic; RAM and ROM reads touch only bytes already written
   task automatic test_mixed_traffic(input int unsigned pct);
      int unsigned stop_at, burst, idx, roll;
      logic [7:0]  c;
      logic [3:0]  grp;
      bit          fill;
      idle_pct = pct;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         burst = $urandom_range(8, 1);
         case ($urandom_range(9))
            0, 1: begin
               // RAM traffic
               repeat (burst) begin
                  if (ram_written_n == 0 || $urandom_range(1) == 0) begin
                     send_cmd(CMD_WRITE, 16'($urandom_range(IO_BASE - 1, 0)), 8'($urandom));
                  end else begin
                     idx = $urandom_range(ram_written_n - 1);
                     send_cmd(($urandom_range(2) == 0) ? CMD_WRITE : CMD_READ,
                              ram_written[idx], 8'($urandom));
                  end
               end
            end
            2, 3, 4: begin
               // keyboard: typing, feeds, strobe clears, latch reads
               fill = ($urandom_range(3) == 0);
               repeat (fill ? 18 : burst * 2) begin
                  roll = $urandom_range(99);
                  case ($urandom_range(5))
                     0, 1: c = 8'($urandom_range(CHAR_LOWER_Z, CHAR_LOWER_A));
                     2:    c = $urandom_range(1) ? KEY_LF : KEY_CR;
                     default: c = 8'($urandom);
                  endcase
                  if (fill || roll < 50) begin
                     send_cmd(CMD_TYPE_KEY, 16'($urandom), c);
                  end else if (roll < 72) begin
                     send_cmd(CMD_FEED, 16'($urandom), c);
                  end else if (roll < 90) begin
                     send_cmd($urandom_range(1) ? CMD_WRITE : CMD_READ,
                              {IO_BASE[15:8], IO_GRP_STROBE, 4'($urandom)}, c);
                  end else begin
                     send_cmd(CMD_READ, {IO_BASE[15:8], IO_GRP_KBD, 4'($urandom)}, '0);
                  end
               end
            end
            5, 6: begin
               // I/O page, mostly the assigned groups
               repeat (burst) begin
                  case ($urandom_range(4))
                     0: grp = IO_GRP_KBD;
                     1: grp = IO_GRP_STROBE;
                     2: grp = IO_GRP_SPEAKER;
                     3: grp = IO_GRP_SWITCH;
                     default: grp = 4'($urandom);
                  endcase
                  send_cmd($urandom_range(1) ? CMD_WRITE : CMD_READ,
                           {IO_BASE[15:8], grp, 4'($urandom)}, 8'($urandom));
               end
            end
            7, 8: begin
               // ROM loads in and out of range, reads of loaded bytes
               repeat (burst) begin
                  roll = $urandom_range(9);
                  if (roll < 4) begin
                     send_cmd(CMD_ROM_LOAD, 16'($urandom_range(ROM_BYTES - 1, 0)),
                              8'($urandom));
                  end else if (roll < 5) begin
                     send_cmd(CMD_ROM_LOAD, 16'($urandom_range(ADDR_TOP, ROM_BYTES)),
                              8'($urandom));
                  end else if (roll < 6) begin
                     send_cmd(CMD_WRITE, 16'($urandom_range(ADDR_TOP, ROM_BASE)),
                              8'($urandom));
                  end else begin
                     idx = $urandom_range(rom_written_n - 1);
                     send_cmd(CMD_READ, ROM_BASE + rom_written[idx], 8'($urandom));
                  end
               end
            end
            default: begin
               // slot area and undefined commands
               repeat (burst) begin
                  roll = $urandom_range(2);
                  if (roll == 0) begin
                     send_cmd(CMD_READ, 16'($urandom_range(SLOT_LAST, SLOT_BASE)), '0);
                  end else if (roll == 1) begin
                     send_cmd(CMD_WRITE, 16'($urandom_range(SLOT_LAST, SLOT_BASE)),
                              8'($urandom));
                  end else begin
                     send_cmd(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                              16'($urandom), 8'($urandom));
                  end
               end
            end
         endcase
      end
      // hold off until all responses are in before the next phase
      wait_idle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rom_window();
      test_ram_and_slots();
      test_io_page();
      test_keyboard_basics();
      test_spare_commands();
      test_mixed_traffic(0);
      test_mixed_traffic(55);
      test_mixed_traffic(0);
      test_mixed_traffic(11);
      $display("Sent %0d commands, checked %0d responses, %0d keys dropped on a full queue,",
               items_sent, replies_seen, keys_dropped);
      $display("%0d RAM and %0d ROM bytes written, speaker count %0d, %0d mismatches.",
               ram_written_n, rom_written_n, spk_count, mismatches);
      if (mismatches == 0) begin
         $display("retro_bus_decode_soft_switches test passed");
      end else begin
         $display("retro_bus_decode_soft_switches test failed");
      end
      $finish;
   end

endmodule
